FILE: design/mup_pkg.sv
// shared types, constants and character helpers for the magnet uri hash parser
// no dependencies
package mup_pkg;

   localparam int HASH_BYTES = 20;
   localparam int DEC_DEPTH  = 2 * HASH_BYTES;
   localparam int IDX_W      = 5;
   localparam logic [3:0] B32_BASE = 4'(8 + 8 - 5);
   localparam logic [3:0] PREFIX_LEN = 4'd8;
   localparam logic [3:0] URN_LEN    = 4'd9;

   localparam logic [7:0] CH_PCT = 8'h25;
   localparam logic [7:0] CH_AMP = 8'h26;
   localparam logic [7:0] CH_EQ  = 8'h3d;
   localparam logic [7:0] CH_X   = 8'h78;
   localparam logic [7:0] CH_T   = 8'h74;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_PREFIX = 3'd1;
   localparam logic [2:0] ST_BAD_URN    = 3'd2;
   localparam logic [2:0] ST_BAD_ESCAPE = 3'd3;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd4;
   localparam logic [2:0] ST_NO_HASH    = 3'd5;

   typedef enum logic [2:0] {
      PH_PREFIX, PH_TAG, PH_URN, PH_VALUE, PH_FAIL
   } phase_type;

   typedef enum logic [1:0] {
      TK_EMPTY, TK_X, TK_XT, TK_OTHER
   } tag_type;

   typedef struct packed {
      logic [2:0]                      status;
      logic [HASH_BYTES-1:0][7:0]      hash;
   } result_type;

   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h57);
      else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h37);
      else r = 5'd16;
      return r;
   endfunction

   function automatic logic [7:0] prefix_char(input logic [2:0] i);
      logic [7:0] r;
      case (i)
         3'd0: r = 8'h6d;
         3'd1: r = 8'h61;
         3'd2: r = 8'h67;
         3'd3: r = 8'h6e;
         3'd4: r = 8'h65;
         3'd5: r = 8'h74;
         3'd6: r = 8'h3a;
         3'd7: r = 8'h3f;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] urn_char(input logic [3:0] i);
      logic [7:0] r;
      case (i)
         4'd0: r = 8'h75;
         4'd1: r = 8'h72;
         4'd2: r = 8'h6e;
         4'd3: r = 8'h3a;
         4'd4: r = 8'h62;
         4'd5: r = 8'h74;
         4'd6: r = 8'h69;
         4'd7: r = 8'h68;
         4'd8: r = 8'h3a;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

FILE: design/mup_front.sv
// character parser: prefix, tags, urn check and three-way value decoding
// depends on mup_pkg; feeds mup_fifo with one finished result record per uri
module mup_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [7:0]          req_char_code,
   input  logic                req_end_of_uri,
   output logic                req_full,
   output logic                q_push,
   output mup_pkg::result_type q_data,
   input  logic                q_full
);

   typedef enum logic [2:0] {FIN_NONE, FIN_B32, FIN_RAW, FIN_HEX, FIN_FAIL} fin_type;

   function automatic fin_type finish_kind(input mup_pkg::tag_type tag, input logic ok,
                                           input logic [4:0] bcnt, input logic [3:0] sh,
                                           input logic [5:0] dlen, input logic hexok);
      fin_type r;
      if (tag != mup_pkg::TK_XT) r = FIN_NONE;
      else if (ok && bcnt == 5'(mup_pkg::HASH_BYTES) && sh == mup_pkg::B32_BASE) r = FIN_B32;
      else if (dlen == 6'(mup_pkg::HASH_BYTES)) r = FIN_RAW;
      else if (dlen == 6'(mup_pkg::DEC_DEPTH)) r = hexok ? FIN_HEX : FIN_FAIL;
      else r = FIN_FAIL;
      return r;
   endfunction

   mup_pkg::phase_type phase_ff, phase_in, cur_phase;
   mup_pkg::tag_type   tag_ff, tag_in, cur_tag;
   logic [3:0]  mcnt_ff, mcnt_in, cur_mcnt;
   logic [15:0] acc_ff, acc_in, cur_acc, acc_or;
   logic [3:0]  shift_ff, shift_in, cur_shift;
   logic [4:0]  bcnt_ff, bcnt_in, cur_bcnt;
   logic        b32ok_ff, b32ok_in, cur_b32ok;
   logic [1:0]  esc_ff, esc_in, cur_esc;
   logic [3:0]  nib_ff, nib_in;
   logic [5:0]  dlen_ff, dlen_in, cur_dlen;
   logic        hexok_ff, hexok_in, cur_hexok;
   logic        hvalid_ff, hvalid_in, cur_hvalid;
   logic [2:0]  err_ff, err_in, cur_err;
   logic        pend_ff, pend_in;

   logic [7:0] b32_mem [mup_pkg::HASH_BYTES];
   logic [7:0] raw_mem [mup_pkg::HASH_BYTES];
   logic [7:0] hex_mem [mup_pkg::HASH_BYTES];
   logic [7:0] hash_ff [mup_pkg::HASH_BYTES];

   logic       accept, restart;
   logic       b32_we, dec_we;
   logic [4:0] b32_idx;
   logic [7:0] b32_dat, dec_dat, c;
   logic [4:0] h, v;
   logic [4:0] dec_hex;
   logic       v_ok;
   fin_type    load_kind, fin_kind;
   logic [2:0] ferr;
   logic       fvalid;

   assign c       = req_char_code;
   assign req_full = pend_ff & q_full;
   assign accept  = req_push & ~req_full;
   assign restart = pend_ff & ~q_full;
   assign q_push  = restart;
   assign dec_hex = mup_pkg::hex_value(dec_dat);

   always_comb begin
      cur_phase  = restart ? mup_pkg::PH_PREFIX : phase_ff;
      cur_tag    = restart ? mup_pkg::TK_EMPTY : tag_ff;
      cur_mcnt   = restart ? 4'd0 : mcnt_ff;
      cur_acc    = restart ? 16'd0 : acc_ff;
      cur_shift  = restart ? mup_pkg::B32_BASE : shift_ff;
      cur_bcnt   = restart ? 5'd0 : bcnt_ff;
      cur_b32ok  = restart ? 1'b1 : b32ok_ff;
      cur_esc    = restart ? 2'd0 : esc_ff;
      cur_dlen   = restart ? 6'd0 : dlen_ff;
      cur_hexok  = restart ? 1'b1 : hexok_ff;
      cur_hvalid = restart ? 1'b0 : hvalid_ff;
      cur_err    = restart ? mup_pkg::ST_OK : err_ff;

      phase_in = cur_phase;
      tag_in   = cur_tag;
      mcnt_in  = cur_mcnt;
      acc_in   = cur_acc;
      shift_in = cur_shift;
      bcnt_in  = cur_bcnt;
      b32ok_in = cur_b32ok;
      esc_in   = cur_esc;
      nib_in   = nib_ff;
      dlen_in  = cur_dlen;
      hexok_in = cur_hexok;
      hvalid_in = cur_hvalid;
      err_in   = cur_err;
      pend_in  = pend_ff & q_full;
      b32_we   = 1'b0;
      b32_idx  = cur_bcnt;
      b32_dat  = 8'd0;
      dec_we   = 1'b0;
      dec_dat  = c;
      load_kind = FIN_NONE;
      h        = mup_pkg::hex_value(c);
      v        = 5'd0;
      v_ok     = 1'b1;
      acc_or   = cur_acc;

      if (c >= 8'h41 && c <= 8'h5a) v = 5'(c - 8'h41);
      else if (c >= 8'h61 && c <= 8'h7a) v = 5'(c - 8'h61);
      else if (c >= 8'h32 && c <= 8'h37) v = 5'(c - 8'd24);
      else v_ok = 1'b0;

      if (accept) begin
         pend_in = req_end_of_uri;
         case (cur_phase)
            mup_pkg::PH_PREFIX: begin
               if (cur_mcnt >= mup_pkg::PREFIX_LEN || c != mup_pkg::prefix_char(cur_mcnt[2:0])) begin
                  if (cur_err == mup_pkg::ST_OK) err_in = mup_pkg::ST_BAD_PREFIX;
                  phase_in = mup_pkg::PH_FAIL;
               end else begin
                  mcnt_in = 4'(cur_mcnt + 4'd1);
                  if (mcnt_in == mup_pkg::PREFIX_LEN) begin
                     phase_in = mup_pkg::PH_TAG;
                     tag_in = mup_pkg::TK_EMPTY;
                  end
               end
            end
            mup_pkg::PH_TAG: begin
               if (c == mup_pkg::CH_EQ) begin
                  if (cur_tag == mup_pkg::TK_XT) begin
                     phase_in = mup_pkg::PH_URN;
                     mcnt_in = 4'd0;
                  end else begin
                     phase_in = mup_pkg::PH_VALUE;
                     acc_in = 16'd0;
                     shift_in = mup_pkg::B32_BASE;
                     bcnt_in = 5'd0;
                     b32ok_in = 1'b1;
                     esc_in = 2'd0;
                     dlen_in = 6'd0;
                     hexok_in = 1'b1;
                  end
               end else if (cur_tag == mup_pkg::TK_EMPTY && c == mup_pkg::CH_X) begin
                  tag_in = mup_pkg::TK_X;
               end else if (cur_tag == mup_pkg::TK_X && c == mup_pkg::CH_T) begin
                  tag_in = mup_pkg::TK_XT;
               end else begin
                  tag_in = mup_pkg::TK_OTHER;
               end
            end
            mup_pkg::PH_URN: begin
               if (cur_mcnt >= mup_pkg::URN_LEN || c != mup_pkg::urn_char(cur_mcnt)) begin
                  if (cur_err == mup_pkg::ST_OK) err_in = mup_pkg::ST_BAD_URN;
                  phase_in = mup_pkg::PH_FAIL;
               end else begin
                  mcnt_in = 4'(cur_mcnt + 4'd1);
                  if (mcnt_in == mup_pkg::URN_LEN) begin
                     phase_in = mup_pkg::PH_VALUE;
                     acc_in = 16'd0;
                     shift_in = mup_pkg::B32_BASE;
                     bcnt_in = 5'd0;
                     b32ok_in = 1'b1;
                     esc_in = 2'd0;
                     dlen_in = 6'd0;
                     hexok_in = 1'b1;
                  end
               end
            end
            mup_pkg::PH_VALUE: begin
               if (cur_esc != 2'd0) begin
                  if (h[4]) begin
                     if (cur_err == mup_pkg::ST_OK) err_in = mup_pkg::ST_BAD_ESCAPE;
                     phase_in = mup_pkg::PH_FAIL;
                  end else if (cur_esc == 2'd1) begin
                     esc_in = 2'd2;
                     nib_in = h[3:0];
                  end else begin
                     dec_we = 1'b1;
                     dec_dat = {nib_ff, h[3:0]};
                     esc_in = 2'd0;
                  end
               end else if (c == mup_pkg::CH_PCT) begin
                  esc_in = 2'd1;
                  b32ok_in = 1'b0;
               end else if (c == mup_pkg::CH_AMP) begin
                  load_kind = finish_kind(cur_tag, cur_b32ok, cur_bcnt, cur_shift, cur_dlen,
                                          cur_hexok);
                  if (load_kind == FIN_FAIL) begin
                     if (cur_err == mup_pkg::ST_OK) err_in = mup_pkg::ST_BAD_LENGTH;
                     phase_in = mup_pkg::PH_FAIL;
                  end else begin
                     if (load_kind != FIN_NONE) hvalid_in = 1'b1;
                     phase_in = mup_pkg::PH_TAG;
                     tag_in = mup_pkg::TK_EMPTY;
                  end
               end else begin
                  dec_we = 1'b1;
                  if (cur_tag == mup_pkg::TK_XT && cur_b32ok) begin
                     if (!v_ok) begin
                        b32ok_in = 1'b0;
                     end else begin
                        acc_or = cur_acc | ({11'd0, v} << cur_shift);
                        if (cur_shift <= 4'd8) begin
                           if (cur_bcnt >= 5'(mup_pkg::HASH_BYTES)) begin
                              b32ok_in = 1'b0;
                              acc_in = acc_or;
                           end else begin
                              b32_we = 1'b1;
                              b32_dat = acc_or[15:8];
                              bcnt_in = 5'(cur_bcnt + 5'd1);
                              acc_in = {acc_or[7:0], 8'd0};
                              shift_in = 4'(cur_shift + 4'd3);
                           end
                        end else begin
                           acc_in = acc_or;
                           shift_in = 4'(cur_shift - 4'd5);
                        end
                     end
                  end
               end
               if (dec_we) begin
                  if (cur_dlen <= 6'(mup_pkg::DEC_DEPTH)) dlen_in = 6'(cur_dlen + 6'd1);
                  if (cur_dlen < 6'(mup_pkg::DEC_DEPTH) && mup_pkg::hex_value(dec_dat) > 5'd15)
                     hexok_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      ferr = err_ff;
      fvalid = hvalid_ff;
      fin_kind = FIN_NONE;
      case (phase_ff)
         mup_pkg::PH_PREFIX: if (ferr == mup_pkg::ST_OK) ferr = mup_pkg::ST_BAD_PREFIX;
         mup_pkg::PH_URN: if (ferr == mup_pkg::ST_OK) ferr = mup_pkg::ST_BAD_URN;
         mup_pkg::PH_VALUE: begin
            if (esc_ff != 2'd0) begin
               if (ferr == mup_pkg::ST_OK) ferr = mup_pkg::ST_BAD_ESCAPE;
            end else begin
               fin_kind = finish_kind(tag_ff, b32ok_ff, bcnt_ff, shift_ff, dlen_ff, hexok_ff);
               if (fin_kind == FIN_FAIL) begin
                  if (ferr == mup_pkg::ST_OK) ferr = mup_pkg::ST_BAD_LENGTH;
               end else if (fin_kind != FIN_NONE) begin
                  fvalid = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      if (ferr != mup_pkg::ST_OK) q_data.status = ferr;
      else if (!fvalid) q_data.status = mup_pkg::ST_NO_HASH;
      else q_data.status = mup_pkg::ST_OK;
      for (int i = 0; i < mup_pkg::HASH_BYTES; i++) begin
         case (fin_kind)
            FIN_B32: q_data.hash[i] = b32_mem[i];
            FIN_RAW: q_data.hash[i] = raw_mem[i];
            FIN_HEX: q_data.hash[i] = hex_mem[i];
            default: q_data.hash[i] = hash_ff[i];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= mup_pkg::PH_PREFIX;
         tag_ff    <= mup_pkg::TK_EMPTY;
         mcnt_ff   <= 4'd0;
         acc_ff    <= 16'd0;
         shift_ff  <= mup_pkg::B32_BASE;
         bcnt_ff   <= 5'd0;
         b32ok_ff  <= 1'b1;
         esc_ff    <= 2'd0;
         dlen_ff   <= 6'd0;
         hexok_ff  <= 1'b1;
         hvalid_ff <= 1'b0;
         err_ff    <= mup_pkg::ST_OK;
         pend_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         tag_ff    <= tag_in;
         mcnt_ff   <= mcnt_in;
         acc_ff    <= acc_in;
         shift_ff  <= shift_in;
         bcnt_ff   <= bcnt_in;
         b32ok_ff  <= b32ok_in;
         esc_ff    <= esc_in;
         dlen_ff   <= dlen_in;
         hexok_ff  <= hexok_in;
         hvalid_ff <= hvalid_in;
         err_ff    <= err_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      nib_ff <= nib_in;
      if (b32_we) b32_mem[b32_idx] <= b32_dat;
      if (dec_we && cur_dlen < 6'(mup_pkg::HASH_BYTES)) raw_mem[cur_dlen[4:0]] <= dec_dat;
      if (dec_we && cur_dlen < 6'(mup_pkg::DEC_DEPTH)) begin
         if (cur_dlen[0]) hex_mem[cur_dlen[5:1]][3:0] <= dec_hex[3:0];
         else hex_mem[cur_dlen[5:1]][7:4] <= dec_hex[3:0];
      end
      for (int i = 0; i < mup_pkg::HASH_BYTES; i++) begin
         case (load_kind)
            FIN_B32: hash_ff[i] <= b32_mem[i];
            FIN_RAW: hash_ff[i] <= raw_mem[i];
            FIN_HEX: hash_ff[i] <= hex_mem[i];
            default: hash_ff[i] <= hash_ff[i];
         endcase
      end
   end

`ifndef SYNTHESIS
   a_push_space: assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("result record pushed into a full queue");
   a_end_pends: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_uri) |=> pend_ff)
      else $error("final character did not raise the pending result");
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && q_full) |-> (req_full && !q_push))
      else $error("parser took input while its result was blocked");
`endif

endmodule

FILE: design/mup_fifo.sv
// short queue of finished result records between parser and result sequencer
// depends on mup_pkg
module mup_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mup_pkg::result_type din,
   output logic                full,
   input  logic                pop,
   output mup_pkg::result_type head,
   output logic                empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   mup_pkg::result_type mem [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign full    = cnt_ff == CW'(DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = mem[rd_ff];

   always_comb begin
      wr_in  = do_push ? ((wr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ff + 1'b1)) : wr_ff;
      rd_in  = do_pop ? ((rd_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ff + 1'b1)) : rd_ff;
      cnt_in = CW'(cnt_ff + CW'(do_push) - CW'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ff] <= din;
   end

endmodule

FILE: design/mup_back.sv
// result sequencer: walks one queued record out as hash bytes or one error item
// depends on mup_pkg; reads the head of mup_fifo
module mup_back (
   input  logic                clock,
   input  logic                reset,
   input  mup_pkg::result_type head,
   input  logic                q_empty,
   output logic                q_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [7:0]          rsp_hash_byte,
   output logic [4:0]          rsp_byte_index,
   output logic [2:0]          rsp_status,
   output logic                rsp_last_result
);

   logic [4:0] idx_ff, idx_in;
   logic       is_err, take;

   assign is_err          = head.status != mup_pkg::ST_OK;
   assign rsp_empty       = q_empty;
   assign rsp_status      = head.status;
   assign rsp_hash_byte   = is_err ? 8'd0 : head.hash[idx_ff];
   assign rsp_byte_index  = is_err ? 5'd0 : idx_ff;
   assign rsp_last_result = is_err || idx_ff == 5'(mup_pkg::HASH_BYTES - 1);
   assign take            = rsp_pop & ~q_empty;
   assign q_pop           = take & rsp_last_result;

   always_comb begin
      idx_in = idx_ff;
      if (take) idx_in = rsp_last_result ? 5'd0 : 5'(idx_ff + 5'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= 5'd0;
      else idx_ff <= idx_in;
   end

`ifndef SYNTHESIS
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= 5'(mup_pkg::HASH_BYTES - 1))
      else $error("byte index ran past the hash");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("record released from an empty queue");
   a_restart: assert property (@(posedge clock) disable iff (reset) q_pop |=> idx_ff == 5'd0)
      else $error("byte index not cleared after the final transfer");
`endif

endmodule

FILE: design/magnet_uri_hash_parser_top.sv
// Magnet URI info-hash parser. One character is taken per cycle, URI after URI, save for one
// stall: after the final character the parser registers a pending record and hands it to a
// QUEUE_DEPTH-entry queue, and input stalls only while it is full. Each value is decoded
// as base32, raw escaped bytes and hex digits at once. Results go out as 20 hash-byte transfers
// per good URI or one error transfer, one per cycle while rsp_pop is high and a record waits.
module magnet_uri_hash_parser_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_uri,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_hash_byte,
   output logic [4:0] rsp_byte_index,
   output logic [2:0] rsp_status,
   output logic       rsp_last_result
);

   mup_pkg::result_type q_din, q_head;
   logic q_push, q_full, q_pop, q_empty;

   mup_front u_front (
      .clock, .reset, .req_push, .req_char_code, .req_end_of_uri, .req_full,
      .q_push, .q_data(q_din), .q_full
   );

   mup_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock, .reset, .push(q_push), .din(q_din), .full(q_full),
      .pop(q_pop), .head(q_head), .empty(q_empty)
   );

   mup_back u_back (
      .clock, .reset, .head(q_head), .q_empty, .q_pop, .rsp_empty, .rsp_pop,
      .rsp_hash_byte, .rsp_byte_index, .rsp_status, .rsp_last_result
   );

endmodule

FILE: tb/sv/tb_magnet_uri_hash_parser_top.sv
// testbench for magnet_uri_hash_parser_top: streams magnet uris and checks hash results
// depends on mup_pkg and the design top; the hash predictor lives in the scoreboard class
module tb_magnet_uri_hash_parser_top;

   typedef struct packed {
      logic [7:0] hash_byte;
      logic [4:0] byte_index;
      logic [2:0] status;
      logic       last_result;
   } hash_result_type;

   int error_count = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   class hash_scoreboard;
      mup_pkg::phase_type phase;
      mup_pkg::tag_type   tag;
      int         match_count;
      logic [15:0] b32_acc;
      int         b32_shift;
      int         b32_count;
      bit         b32_ok;
      int         esc_stage;
      logic [3:0] esc_high;
      logic [7:0] decoded [mup_pkg::DEC_DEPTH];
      int         decoded_len;
      logic [7:0] hash [mup_pkg::HASH_BYTES];
      bit         hash_ok;
      logic [2:0] err;
      hash_result_type pending [$];

      function new();
         clear();
      endfunction

      function void clear();
         phase = mup_pkg::PH_PREFIX;
         tag = mup_pkg::TK_EMPTY;
         match_count = 0;
         value_begin();
         foreach (decoded[i]) decoded[i] = 8'h00;
         foreach (hash[i]) hash[i] = 8'h00;
         hash_ok = 0;
         err = mup_pkg::ST_OK;
      endfunction

      function void value_begin();
         b32_acc = 16'h0;
         b32_shift = int'(mup_pkg::B32_BASE);
         b32_count = 0;
         b32_ok = 1;
         esc_stage = 0;
         esc_high = 4'h0;
         decoded_len = 0;
      endfunction

      function void fail_with(input logic [2:0] code);
         if (err == mup_pkg::ST_OK) err = code;
         phase = mup_pkg::PH_FAIL;
      endfunction

      function int hex_of(input logic [7:0] c);
         if (c >= "0" && c <= "9") return c - "0";
         if (c >= "a" && c <= "f") return c - "a" + 10;
         if (c >= "A" && c <= "F") return c - "A" + 10;
         return 16;
      endfunction

      function void push_decoded(input logic [7:0] b);
         if (decoded_len < mup_pkg::DEC_DEPTH) decoded[decoded_len] = b;
         if (decoded_len <= mup_pkg::DEC_DEPTH) decoded_len++;
      endfunction

      function void base32_take(input logic [7:0] c);
         int v;
         if (!b32_ok) return;
         if (c >= "A" && c <= "Z") v = c - "A";
         else if (c >= "a" && c <= "z") v = c - "a";
         else if (c >= "2" && c <= "7") v = 26 + c - "2";
         else begin
            b32_ok = 0;
            return;
         end
         b32_acc = b32_acc | 16'((v << b32_shift) & 32'hffff);
         if (b32_shift <= 8) begin
            if (b32_count >= mup_pkg::HASH_BYTES) begin
               b32_ok = 0;
               return;
            end
            hash[b32_count] = b32_acc[15:8];
            b32_count++;
            b32_acc = b32_acc << 8;
            b32_shift += 3;
         end else begin
            b32_shift -= 5;
         end
      endfunction

      function void close_value();
         if (tag != mup_pkg::TK_XT) return;
         if (b32_ok && b32_count == mup_pkg::HASH_BYTES &&
             b32_shift == int'(mup_pkg::B32_BASE)) begin
            hash_ok = 1;
         end else if (decoded_len == mup_pkg::HASH_BYTES) begin
            for (int i = 0; i < mup_pkg::HASH_BYTES; i++) hash[i] = decoded[i];
            hash_ok = 1;
         end else if (decoded_len == mup_pkg::DEC_DEPTH) begin
            for (int i = 0; i < mup_pkg::DEC_DEPTH; i++)
               if (hex_of(decoded[i]) > 15) begin
                  fail_with(mup_pkg::ST_BAD_LENGTH);
                  return;
               end
            for (int i = 0; i < mup_pkg::HASH_BYTES; i++)
               hash[i] = 8'((hex_of(decoded[2*i]) << 4) | hex_of(decoded[2*i+1]));
            hash_ok = 1;
         end else begin
            fail_with(mup_pkg::ST_BAD_LENGTH);
         end
      endfunction

      function void value_char(input logic [7:0] c);
         int h;
         if (esc_stage != 0) begin
            h = hex_of(c);
            if (h > 15) begin
               fail_with(mup_pkg::ST_BAD_ESCAPE);
               return;
            end
            if (esc_stage == 1) begin
               esc_stage = 2;
               esc_high = 4'(h);
            end else begin
               push_decoded({esc_high, 4'(h)});
               esc_stage = 0;
            end
         end else if (c == mup_pkg::CH_PCT) begin
            esc_stage = 1;
            b32_ok = 0;
         end else if (c == mup_pkg::CH_AMP) begin
            close_value();
            if (phase == mup_pkg::PH_VALUE) begin
               phase = mup_pkg::PH_TAG;
               tag = mup_pkg::TK_EMPTY;
            end
         end else begin
            push_decoded(c);
            if (tag == mup_pkg::TK_XT) base32_take(c);
         end
      endfunction

      // note an accepted input transfer
      function void note_char(input logic [7:0] c, input bit last);
         hash_result_type r;
         case (phase)
            mup_pkg::PH_PREFIX: begin
               if (match_count >= 8 || c != mup_pkg::prefix_char(3'(match_count)))
                  fail_with(mup_pkg::ST_BAD_PREFIX);
               else if (++match_count == 8) begin
                  phase = mup_pkg::PH_TAG;
                  tag = mup_pkg::TK_EMPTY;
               end
            end
            mup_pkg::PH_TAG: begin
               if (c == mup_pkg::CH_EQ) begin
                  if (tag == mup_pkg::TK_XT) begin
                     phase = mup_pkg::PH_URN;
                     match_count = 0;
                  end else begin
                     phase = mup_pkg::PH_VALUE;
                     value_begin();
                  end
               end else if (tag == mup_pkg::TK_EMPTY && c == mup_pkg::CH_X) tag = mup_pkg::TK_X;
               else if (tag == mup_pkg::TK_X && c == mup_pkg::CH_T) tag = mup_pkg::TK_XT;
               else tag = mup_pkg::TK_OTHER;
            end
            mup_pkg::PH_URN: begin
               if (match_count >= 9 || c != mup_pkg::urn_char(4'(match_count)))
                  fail_with(mup_pkg::ST_BAD_URN);
               else if (++match_count == 9) begin
                  phase = mup_pkg::PH_VALUE;
                  value_begin();
               end
            end
            mup_pkg::PH_VALUE: value_char(c);
            default: ;
         endcase
         if (!last) return;
         if (phase == mup_pkg::PH_PREFIX) fail_with(mup_pkg::ST_BAD_PREFIX);
         else if (phase == mup_pkg::PH_URN) fail_with(mup_pkg::ST_BAD_URN);
         else if (phase == mup_pkg::PH_VALUE) begin
            if (esc_stage != 0) fail_with(mup_pkg::ST_BAD_ESCAPE);
            else close_value();
         end
         if (err != mup_pkg::ST_OK || !hash_ok) begin
            r.hash_byte = 8'h00;
            r.byte_index = 5'd0;
            r.status = (err != mup_pkg::ST_OK) ? err : mup_pkg::ST_NO_HASH;
            r.last_result = 1'b1;
            pending.insert(pending.size(), r);
         end else begin
            for (int i = 0; i < mup_pkg::HASH_BYTES; i++) begin
               r.hash_byte = hash[i];
               r.byte_index = 5'(i);
               r.status = mup_pkg::ST_OK;
               r.last_result = (i == mup_pkg::HASH_BYTES - 1);
               pending.insert(pending.size(), r);
            end
         end
         clear();
      endfunction

      // check an accepted result transfer
      task check_result(input hash_result_type got);
         hash_result_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected result, index", got.byte_index, 0);
            return;
         end
         want = pending.pop_front();
         if (got.hash_byte != want.hash_byte)
            report_mismatch("hash_byte", got.hash_byte, want.hash_byte);
         if (got.byte_index != want.byte_index)
            report_mismatch("byte_index", got.byte_index, want.byte_index);
         if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
         if (got.last_result != want.last_result)
            report_mismatch("last_result", got.last_result, want.last_result);
      endtask
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       req_push = 0;
   logic       req_full;
   logic [7:0] req_char_code = 8'h00;
   logic       req_end_of_uri = 0;
   logic       rsp_empty;
   logic       rsp_pop = 0;
   logic [7:0] rsp_hash_byte;
   logic [4:0] rsp_byte_index;
   logic [2:0] rsp_status;
   logic       rsp_last_result;

   hash_scoreboard hash_board = new();
   bit   sending_done = 0;
   bit   hold_off = 0;

   magnet_uri_hash_parser_top i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_char_code(req_char_code), .req_end_of_uri(req_end_of_uri),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_hash_byte(rsp_hash_byte), .rsp_byte_index(rsp_byte_index),
      .rsp_status(rsp_status), .rsp_last_result(rsp_last_result)
   );

   always #6 clock = ~clock;

   // burst and gap control for the sender
   int burst_left = 0;
   int gap_left = 0;

   task automatic send_char(input logic [7:0] c, input bit last);
      while (gap_left > 0) begin
         gap_left--;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_char_code <= c;
      req_end_of_uri <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      hash_board.note_char(c, last);
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 30);
         gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      end
      if (gap_left > 0) req_push <= 1'b0;
   endtask

   task automatic send_uri(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   function automatic string hex_text(input int n, input bit upper);
      string s = "";
      string digits;
      digits = upper ? "0123456789ABCDEF" : "0123456789abcdef";
      for (int i = 0; i < n; i++) s = {s, string'(digits[$urandom_range(0, 15)])};
      return s;
   endfunction

   function automatic string b32_text(input int n);
      string s = "";
      string alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz234567";
      for (int i = 0; i < n; i++) s = {s, string'(alpha[$urandom_range(0, alpha.len() - 1)])};
      return s;
   endfunction

   // result side: random stall pattern plus one long hold-off
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty)
            hash_board.check_result({rsp_hash_byte, rsp_byte_index, rsp_status, rsp_last_result});
         rsp_pop <= !hold_off && ($urandom_range(0, 7) < 5 || sending_done);
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_uri({"magnet:?xt=urn:btih:", b32_text(32)});
      send_uri({"magnet:?xt=urn:btih:", hex_text(40, $urandom_range(0, 1))});
      send_uri("magnet:?xt=urn:btih:%00%FF%ff%7f%26aaaaaaaaaaaaaaa&dn=x");
      send_uri({"magnet:?xt=urn:btih:", hex_text(39, 1'b0), "z"});
      send_uri("magnet");
      send_uri("magnet:?a&xt");
      send_uri("magnet:?xt=urn:bt");
      send_uri("magnet:?a=%4");
      send_uri("magnet:?a=%4g");
      send_uri("magnet:?a=%&1");
      send_char(8'hff, 1'b1);
      send_char(8'h01, 1'b1);
      // long receiver hold-off so the queue fills
      hold_off = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         for (int k = 0; k < 4; k++) send_char(8'($urandom_range(1, 255)), 1'b1);
      join
      if (gap_left == 0) req_push <= 1'b0;
      sending_done = 1;
      while (hash_board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && hash_board.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("TB_ERROR");
      $finish;
   end
endmodule

FILE: files.f
design/mup_pkg.sv
design/mup_front.sv
design/mup_fifo.sv
design/mup_back.sv
design/magnet_uri_hash_parser_top.sv
tb/sv/tb_magnet_uri_hash_parser_top.sv
